// ===== hw/rtl/wpie_pkg.sv =====
// ----------------------------------------------------------------------------
// wpie_pkg - shared types and constants of the peak intensity extractor
// Request and response payloads, the internal command and the engine states.
// ----------------------------------------------------------------------------
package wpie_pkg;

   localparam int MAX_PEAKS_DEFAULT   = 4096;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [23:0] MZ_WINDOW_RESET = 24'd3277;
   localparam logic [24:0] PPM_SCALE       = 25'd32000000;
   localparam logic [47:0] SUM_MAX         = 48'hFFFF_FFFF_FFFF;

   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] CSR_WINDOW_MODE = 2'd0;
   localparam logic [1:0] CSR_MZ_WINDOW   = 2'd1;
   localparam logic [1:0] CSR_RT_WINDOW   = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] spectrum_rt;
      logic [31:0] peak_mz;
      logic [31:0] peak_intensity;
      logic [31:0] target_mz;
      logic [23:0] target_rt;
   } req_type;

   typedef struct packed {
      logic [23:0] point_time;
      logic [47:0] extracted_intensity;
      logic        peaks_dropped;
      logic        order_error;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_BEGIN,
      CMD_LOAD,
      CMD_QUERY
   } cmd_kind_type;

   // begin: rt; load: mz/value; query: mz/rt
   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  mz;
      logic [31:0]  value;
      logic [23:0]  rt;
   } cmd_type;

   typedef struct packed {
      logic        window_mode;
      logic [23:0] mz_window;
      logic [23:0] rt_window;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_LEFT_RD,
      ST_LEFT_CHK,
      ST_RIGHT_RD,
      ST_RIGHT_CHK,
      ST_OUT
   } state_type;

endpackage

// ===== hw/rtl/wpie_front.sv =====
// ----------------------------------------------------------------------------
// wpie_front - request intake
// Registers each request, classifies its op and drops unused op codes.
// ----------------------------------------------------------------------------
module wpie_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wpie_pkg::req_type req_data,
   output logic              push,
   output wpie_pkg::cmd_type push_cmd,
   input  logic              queue_full
);

   logic              valid_ff, valid_in;
   wpie_pkg::cmd_type cmd_ff, cmd_in;
   logic              accept, keep;

   assign push      = valid_ff && !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push_cmd  = cmd_ff;

   always_comb begin
      cmd_in = cmd_ff;
      keep   = 1'b1;
      unique case (req_data.op)
         wpie_pkg::OP_BEGIN: begin
            cmd_in.kind  = wpie_pkg::CMD_BEGIN;
            cmd_in.mz    = '0;
            cmd_in.value = '0;
            cmd_in.rt    = req_data.spectrum_rt;
         end
         wpie_pkg::OP_LOAD: begin
            cmd_in.kind  = wpie_pkg::CMD_LOAD;
            cmd_in.mz    = req_data.peak_mz;
            cmd_in.value = req_data.peak_intensity;
            cmd_in.rt    = '0;
         end
         wpie_pkg::OP_QUERY: begin
            cmd_in.kind  = wpie_pkg::CMD_QUERY;
            cmd_in.mz    = req_data.target_mz;
            cmd_in.value = '0;
            cmd_in.rt    = req_data.target_rt;
         end
         default: keep = 1'b0;
      endcase
      valid_in = push ? 1'b0 : valid_ff;
      if (accept && keep) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== hw/rtl/wpie_queue.sv =====
// ----------------------------------------------------------------------------
// wpie_queue - command queue
// Small first-in first-out store between intake and engine.
// ----------------------------------------------------------------------------
module wpie_queue #(
   parameter int DEPTH = wpie_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wpie_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output wpie_pkg::cmd_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   wpie_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] fill_ff, fill_in;

   assign full  = (fill_ff == CW'(DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = entry_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/wpie_engine.sv =====
// ----------------------------------------------------------------------------
// wpie_engine - peak store and window walk
// Executes begin, load and query commands against the peak memory.
// ----------------------------------------------------------------------------
module wpie_engine #(
   parameter int MAX_PEAKS = wpie_pkg::MAX_PEAKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  wpie_pkg::cfg_type cfg,
   input  logic              empty,
   input  wpie_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wpie_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_PEAKS);
   localparam int CW = $clog2(MAX_PEAKS + 1);

   logic [31:0] mz_mem  [MAX_PEAKS];
   logic [31:0] int_mem [MAX_PEAKS];
   logic [31:0] rd_mz_ff, rd_int_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   wpie_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, cursor_ff, cursor_in, idx_ff, idx_in;
   logic [23:0]   spec_rt_ff, spec_rt_in;
   logic [31:0]   prev_ff, prev_in, tmz_ff, tmz_in;
   logic          ovf_ff, ovf_in, oerr_ff, oerr_in;
   logic [55:0]   prod_ff, prod_in;
   logic [47:0]   sum_ff, sum_in;
   logic          rv_ff, rv_in;
   wpie_pkg::rsp_type rsp_ff, rsp_in;

   logic [23:0] rt_d;
   logic        gate_ok, in_win;
   logic [31:0] d;
   logic [56:0] lhs;
   logic [48:0] sum_add;
   logic        is_query, out_free;

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rv_ff || !rsp_stall;
   assign is_query  = !empty && (head.kind == wpie_pkg::CMD_QUERY);

   always_comb begin
      rt_d    = (spec_rt_ff >= head.rt) ? spec_rt_ff - head.rt : head.rt - spec_rt_ff;
      gate_ok = (cfg.rt_window == '0) || ({rt_d, 1'b0} <= {1'b0, cfg.rt_window});
      d       = (rd_mz_ff >= tmz_ff) ? rd_mz_ff - tmz_ff : tmz_ff - rd_mz_ff;
      lhs     = 57'(d) * 57'(wpie_pkg::PPM_SCALE);
      in_win  = cfg.window_mode ? (lhs < {1'b0, prod_ff})
                                : ({d, 1'b0} < {9'd0, cfg.mz_window});
      sum_add = {1'b0, sum_ff} + {17'd0, rd_int_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wpie_pkg::ST_IDLE: begin
            if (is_query && count_ff != '0 && gate_ok) begin
               state_in = wpie_pkg::ST_SCAN_RD;
            end
         end
         wpie_pkg::ST_SCAN_RD:
            state_in = (cursor_ff < count_ff) ? wpie_pkg::ST_SCAN_CHK : wpie_pkg::ST_LEFT_RD;
         wpie_pkg::ST_SCAN_CHK:
            state_in = (rd_mz_ff < tmz_ff) ? wpie_pkg::ST_SCAN_RD : wpie_pkg::ST_LEFT_RD;
         wpie_pkg::ST_LEFT_RD:
            state_in = (idx_ff != '0) ? wpie_pkg::ST_LEFT_CHK : wpie_pkg::ST_RIGHT_RD;
         wpie_pkg::ST_LEFT_CHK:
            state_in = in_win ? wpie_pkg::ST_LEFT_RD : wpie_pkg::ST_RIGHT_RD;
         wpie_pkg::ST_RIGHT_RD:
            state_in = (idx_ff < count_ff) ? wpie_pkg::ST_RIGHT_CHK : wpie_pkg::ST_OUT;
         wpie_pkg::ST_RIGHT_CHK:
            state_in = in_win ? wpie_pkg::ST_RIGHT_RD : wpie_pkg::ST_OUT;
         wpie_pkg::ST_OUT:
            if (out_free) begin
               state_in = wpie_pkg::ST_IDLE;
            end
         default: state_in = wpie_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop        = 1'b0;
      wr_en      = 1'b0;
      rd_addr    = cursor_ff[AW-1:0];
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      idx_in     = idx_ff;
      spec_rt_in = spec_rt_ff;
      prev_in    = prev_ff;
      tmz_in     = tmz_ff;
      ovf_in     = ovf_ff;
      oerr_in    = oerr_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;
      rv_in      = rv_ff && rsp_stall;
      rsp_in     = rsp_ff;
      unique case (state_ff)
         wpie_pkg::ST_IDLE: begin
            pop = !empty;
            if (!empty) begin
               unique case (head.kind)
                  wpie_pkg::CMD_BEGIN: begin
                     spec_rt_in = head.rt;
                     count_in   = '0;
                     cursor_in  = '0;
                     prev_in    = '0;
                     ovf_in     = 1'b0;
                  end
                  wpie_pkg::CMD_LOAD: begin
                     if (count_ff == CW'(MAX_PEAKS)) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     oerr_in = head.mz < prev_ff;
                     prev_in = head.mz;
                     tmz_in  = head.mz;
                     prod_in = 56'(head.mz) * 56'(cfg.mz_window);
                     sum_in  = '0;
                  end
               endcase
            end
         end
         wpie_pkg::ST_SCAN_RD: begin
            rd_addr = cursor_ff[AW-1:0];
            idx_in  = cursor_ff;
         end
         wpie_pkg::ST_SCAN_CHK: begin
            if (rd_mz_ff < tmz_ff) begin
               cursor_in = cursor_ff + 1'b1;
            end
            idx_in = cursor_ff;
         end
         wpie_pkg::ST_LEFT_RD: begin
            rd_addr = AW'(idx_ff - 1'b1);
            if (idx_ff == '0) begin
               idx_in = cursor_ff;
            end
         end
         wpie_pkg::ST_LEFT_CHK: begin
            if (in_win) begin
               sum_in = sum_add[48] ? wpie_pkg::SUM_MAX : sum_add[47:0];
               idx_in = idx_ff - 1'b1;
            end else begin
               idx_in = cursor_ff;
            end
         end
         wpie_pkg::ST_RIGHT_RD: begin
            rd_addr = idx_ff[AW-1:0];
         end
         wpie_pkg::ST_RIGHT_CHK: begin
            if (in_win) begin
               sum_in = sum_add[48] ? wpie_pkg::SUM_MAX : sum_add[47:0];
               idx_in = idx_ff + 1'b1;
            end
         end
         wpie_pkg::ST_OUT: begin
            if (out_free) begin
               rv_in                      = 1'b1;
               rsp_in.point_time          = spec_rt_ff;
               rsp_in.extracted_intensity = sum_ff;
               rsp_in.peaks_dropped       = ovf_ff;
               rsp_in.order_error         = oerr_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mz_mem[count_ff[AW-1:0]]  <= head.mz;
         int_mem[count_ff[AW-1:0]] <= head.value;
      end
      rd_mz_ff  <= mz_mem[rd_addr];
      rd_int_ff <= int_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wpie_pkg::ST_IDLE;
         count_ff   <= '0;
         cursor_ff  <= '0;
         spec_rt_ff <= '0;
         prev_ff    <= '0;
         ovf_ff     <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         spec_rt_ff <= spec_rt_in;
         prev_ff    <= prev_in;
         ovf_ff     <= ovf_in;
         rv_ff      <= rv_in;
      end
      idx_ff  <= idx_in;
      tmz_ff  <= tmz_in;
      oerr_ff <= oerr_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rsp_ff  <= rsp_in;
   end

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff) else $error("cursor beyond peak count");
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CW'(MAX_PEAKS)) else $error("overflow without full store");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == wpie_pkg::ST_IDLE) else $error("pop outside idle");
   a_out_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpie_pkg::ST_OUT && out_free) |=> rv_ff) else $error("result lost");

endmodule

// ===== hw/rtl/windowed_peak_intensity_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_peak_intensity_extractor_unit - windowed peak intensity extractor
// Sums peak intensities inside an mz window around each query target.
// ----------------------------------------------------------------------------
// Begin and load pass the intake register and the queue and execute in the idle state.
// A query that passes the rt gate on a non-empty store holds the engine while it
// advances the cursor, sums the in-window peaks left and then right of it, each read
// through the single read port of the peak memory, and emits the result. One command
// is in the engine at a time; the queue absorbs bursts. Reset is synchronous, active
// high; the peak memory is not cleared, only entries below the peak count are ever used.
module windowed_peak_intensity_extractor_unit #(
   parameter int MAX_PEAKS   = wpie_pkg::MAX_PEAKS_DEFAULT,
   parameter int QUEUE_DEPTH = wpie_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wpie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wpie_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   wpie_pkg::cfg_type cfg_ff, cfg_in;
   wpie_pkg::cmd_type push_cmd, head;
   logic push, pop, full, empty;

   // hold the registers; write only the addressed one, ignore unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            wpie_pkg::CSR_WINDOW_MODE: cfg_in.window_mode = csr_wdata[0];
            wpie_pkg::CSR_MZ_WINDOW:   cfg_in.mz_window   = csr_wdata;
            wpie_pkg::CSR_RT_WINDOW:   cfg_in.rt_window   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_mode <= 1'b0;
         cfg_ff.mz_window   <= wpie_pkg::MZ_WINDOW_RESET;
         cfg_ff.rt_window   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // intake: register and classify each request
   wpie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (full)
   );

   // decouple intake from the engine
   wpie_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   // execute against the peak store and drive the response register
   wpie_engine #(.MAX_PEAKS(MAX_PEAKS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb_windowed_peak_intensity_extractor_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_peak_intensity_extractor_unit - self-checking bench
// Drives begin, load and query requests, predicts each window sum in the
// bench itself and checks every response field, under varied idling.
// ----------------------------------------------------------------------------
module tb_windowed_peak_intensity_extractor_unit;

   localparam int MAXP = wpie_pkg::MAX_PEAKS_DEFAULT;
   localparam int IW   = $clog2(MAXP);
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   wpie_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   wpie_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [23:0]       csr_wdata = '0;

   windowed_peak_intensity_extractor_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [31:0] spec_mz [MAXP];
   logic [31:0] spec_int [MAXP];
   int unsigned spec_count, walk_pos;
   logic [23:0] spec_rt;
   logic [31:0] last_target;
   logic        spill_seen;
   logic        mode_ppm;
   logic [23:0] mz_width, rt_gate;

   wpie_pkg::rsp_type expected_rsps [$];
   int          error_count = 0;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   logic [31:0] sorted_mz;  // running mz for well-formed loads

   initial forever #5 clock = ~clock;

   // Hold the run to a bounded time.
   initial begin
      #50ms;
      $display("tb_windowed_peak_intensity_extractor_unit: errors");
      $finish;
   end

   function automatic bit peak_in_window(logic [31:0] pk, logic [31:0] centre);
      logic [63:0] d;
      d = (pk >= centre) ? 64'(pk - centre) : 64'(centre - pk);
      if (mode_ppm) return d * 64'd32000000 < 64'(centre) * 64'(mz_width);
      return 64'd2 * d < 64'(mz_width);
   endfunction

   function automatic logic [47:0] sum_saturating(logic [47:0] acc, logic [31:0] v);
      logic [48:0] s;
      s = 49'(acc) + 49'(v);
      return s > 49'(wpie_pkg::SUM_MAX) ? wpie_pkg::SUM_MAX : s[47:0];
   endfunction

   // Advance the predictor over one accepted request.
   task automatic predict_request(wpie_pkg::req_type r);
      logic [63:0] d;
      logic [47:0] acc;
      int unsigned i;
      wpie_pkg::rsp_type e;
      bit          order_bad;
      case (r.op)
         wpie_pkg::OP_BEGIN: begin
            spec_rt = r.spectrum_rt; spec_count = 0; walk_pos = 0;
            last_target = '0; spill_seen = 1'b0;
         end
         wpie_pkg::OP_LOAD: begin
            if (spec_count >= MAXP) spill_seen = 1'b1;
            else begin
               spec_mz[IW'(spec_count)]  = r.peak_mz;
               spec_int[IW'(spec_count)] = r.peak_intensity;
               spec_count++;
            end
         end
         wpie_pkg::OP_QUERY: begin
            order_bad = r.target_mz < last_target;
            last_target = r.target_mz;
            if (spec_count == 0) return;
            if (rt_gate != '0) begin
               d = (spec_rt >= r.target_rt) ? 64'(spec_rt - r.target_rt)
                                            : 64'(r.target_rt - spec_rt);
               if (64'd2 * d > 64'(rt_gate)) return;
            end
            if (walk_pos > spec_count) walk_pos = spec_count;
            while (walk_pos < spec_count && spec_mz[IW'(walk_pos)] < r.target_mz) walk_pos++;
            acc = '0;
            i = walk_pos;
            while (i > 0 && peak_in_window(spec_mz[IW'(i-1)], r.target_mz)) begin
               acc = sum_saturating(acc, spec_int[IW'(i-1)]); i--;
            end
            i = walk_pos;
            while (i < spec_count && peak_in_window(spec_mz[IW'(i)], r.target_mz)) begin
               acc = sum_saturating(acc, spec_int[IW'(i)]); i++;
            end
            e.point_time = spec_rt; e.extracted_intensity = acc;
            e.peaks_dropped = spill_seen; e.order_error = order_bad;
            expected_rsps = {expected_rsps, e};
         end
         default: ;
      endcase
   endtask

   // Send one request and wait for its acceptance; valid stays up for the next one.
   task automatic send_request(wpie_pkg::req_type r);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(r);
   endtask

   // Randomise the receiver stall every cycle.
   always @(posedge clock) begin
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            error_count++;
         end else begin : cmp
            wpie_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data.point_time !== e.point_time) begin
               $error("point_time exp %h got %h", e.point_time, rsp_data.point_time);
               error_count++;
            end
            if (rsp_data.extracted_intensity !== e.extracted_intensity) begin
               $error("extracted_intensity exp %h got %h",
                      e.extracted_intensity, rsp_data.extracted_intensity);
               error_count++;
            end
            if (rsp_data.peaks_dropped !== e.peaks_dropped) begin
               $error("peaks_dropped exp %b got %b", e.peaks_dropped, rsp_data.peaks_dropped);
               error_count++;
            end
            if (rsp_data.order_error !== e.order_error) begin
               $error("order_error exp %b got %b", e.order_error, rsp_data.order_error);
               error_count++;
            end
         end
      end
   end

   // Drop valid, drain outstanding responses, then let the engine settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] val);
      req_valid <= 1'b0;
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         wpie_pkg::CSR_WINDOW_MODE: mode_ppm = val[0];
         wpie_pkg::CSR_MZ_WINDOW:   mz_width = val;
         wpie_pkg::CSR_RT_WINDOW:   rt_gate  = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic wpie_pkg::req_type make_req(logic [1:0] op);
      wpie_pkg::req_type r;
      r.op             = op;
      r.spectrum_rt    = 24'($urandom);
      r.peak_mz        = $urandom;
      r.peak_intensity = $urandom;
      r.target_mz      = $urandom;
      r.target_rt      = 24'($urandom);
      return r;
   endfunction

   task automatic do_begin(logic [23:0] rt);
      wpie_pkg::req_type r;
      r = make_req(wpie_pkg::OP_BEGIN); r.spectrum_rt = rt;
      send_request(r);
   endtask

   task automatic do_load(logic [31:0] mz, logic [31:0] inten);
      wpie_pkg::req_type r;
      r = make_req(wpie_pkg::OP_LOAD); r.peak_mz = mz; r.peak_intensity = inten;
      send_request(r);
   endtask

   task automatic do_query(logic [31:0] mz, logic [23:0] rt);
      wpie_pkg::req_type r;
      r = make_req(wpie_pkg::OP_QUERY); r.target_mz = mz; r.target_rt = rt;
      send_request(r);
   endtask

   // Extremes of fields, empty spectrum, unused op, descending target.
   task automatic test_directed;
      wpie_pkg::req_type r;
      do_query(32'h100, 24'd0);             // empty spectrum: no response
      do_load(32'h1000, 32'hFFFF_FFFF);     // load before any begin
      do_query(32'h1000, 24'hFFFFFF);
      do_begin(24'hFFFFFF);
      do_load(32'd0, 32'hFFFF_FFFF);
      do_load(32'd1, 32'hFFFF_FFFF);
      do_load(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      do_query(32'd0, 24'd0);               // first peak counted
      do_query(32'hFFFF_FFFF, 24'd0);       // last peak once
      do_query(32'd2, 24'd0);               // descending target
      r = make_req(OP_SPARE);               // unused op ignored
      send_request(r);
      drain();
      write_csr(wpie_pkg::CSR_WINDOW_MODE, 24'd1);
      write_csr(wpie_pkg::CSR_MZ_WINDOW, 24'hFFFFFF);
      do_begin(24'd100);
      for (int i = 0; i < 6; i++) do_load(32'h7FFF_0000 + i * 32'h1000_0000, 32'hFFFF_FFFF);
      do_query(32'hFFFF_FFFF, 24'd0);
      drain();
      write_csr(wpie_pkg::CSR_WINDOW_MODE, 24'd0);
      write_csr(wpie_pkg::CSR_MZ_WINDOW, 24'd0);
      write_csr(wpie_pkg::CSR_RT_WINDOW, 24'hFFFFFF);
      do_query(32'hFFFF_FFFF, 24'hFFFFFF);
      drain();
   endtask

   // Well-formed spectra with random content, plus some noise.
   task automatic test_random(int n_items);
      int sent;
      logic [31:0] tmz;
      sent = 0;
      while (sent < n_items) begin
         do_begin($urandom_range(1) ? 24'($urandom_range(2000)) : 24'($urandom));
         sent++;
         sorted_mz = $urandom_range(3) == 0 ? $urandom : $urandom_range(100000);
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(15) == 0) do_load($urandom, $urandom);
            else begin
               sorted_mz = sorted_mz + $urandom_range(4000);
               do_load(sorted_mz, $urandom_range(1) ? $urandom : $urandom_range(1000));
            end
            sent++;
         end
         tmz = sorted_mz - $urandom_range(30000);
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(9) == 0) tmz = $urandom;
            else tmz = tmz + $urandom_range(6000);
            do_query(tmz, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(2000)));
            sent++;
         end
         if ($urandom_range(19) == 0) begin
            send_request(make_req(OP_SPARE));
            sent++;
         end
      end
   endtask

   task automatic run_phase(int s_idle, int r_idle, logic mode, logic [23:0] mzw,
                            logic [23:0] rtw, int n_items);
      drain();
      send_idle_pct = s_idle; recv_idle_pct = r_idle;
      write_csr(wpie_pkg::CSR_WINDOW_MODE, 24'(mode));
      write_csr(wpie_pkg::CSR_MZ_WINDOW, mzw);
      write_csr(wpie_pkg::CSR_RT_WINDOW, rtw);
      test_random(n_items);
   endtask

   initial begin
      mode_ppm = 1'b0; mz_width = wpie_pkg::MZ_WINDOW_RESET; rt_gate = '0;
      spec_count = 0; walk_pos = 0; spec_rt = '0; last_target = '0; spill_seen = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 13; recv_idle_pct = 86;
      test_directed();
      run_phase(13, 86, 1'b0, wpie_pkg::MZ_WINDOW_RESET, 24'd0, 145);
      run_phase(13, 86, 1'b1, 24'hFFFFFF, 24'd0, 145);
      run_phase(86, 13, 1'b1, 24'd320, 24'd1500, 145);
      run_phase(0, 0, 1'b0, 24'd12000, 24'd600, 145);
      run_phase(0, 0, 1'b0, 24'd1, 24'd1, 145);
      drain();
      if (error_count == 0) $display("tb_windowed_peak_intensity_extractor_unit: clean");
      else $display("tb_windowed_peak_intensity_extractor_unit: errors");
      $finish;
   end

endmodule
